// ===== rtl/cascaded_irq_decode_and_mask_macros.svh =====
// Assertion macros for the cascaded interrupt decode and mask block.
// Expects clk and rst_n in the scope of each use.
`ifndef CASCADED_IRQ_DECODE_AND_MASK_MACROS_SVH
`define CASCADED_IRQ_DECODE_AND_MASK_MACROS_SVH

// same-cycle implication
`define CIDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CIDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cidm_pkg.sv =====
// Package for the cascaded interrupt decode and mask block.
// Action codes, source bit groups, shortcut table and bit-search helpers.
// No dependencies.
`timescale 1ns / 1ps

package cidm_pkg;

  localparam int NUM_CORES_DEF = 4;

  localparam int IN_DATA_W  = 104; // core..bank_two_pending, 13 bytes
  localparam int IN_USER_W  = 3;   // action
  localparam int OUT_DATA_W = 16;  // active_irq, nothing_pending, is_enabled

  localparam logic [9:0]  TIMER_BITS  = 10'h00f;
  localparam logic [9:0]  MBOX_BITS   = 10'h0f0;
  localparam logic [6:0]  CASCADE_IRQ = 7'd8;
  localparam logic [6:0]  PMU_IRQ     = 7'd9;
  localparam int          PMU_BIT     = 9;
  localparam logic [20:0] BASIC_BITS  = 21'h0000ff;
  localparam int          BANK1_FLAG  = 8;
  localparam int          BANK2_FLAG  = 9;
  localparam logic [20:0] SC_BITS     = 21'h1ffc00; // bank 1 and bank 2 shortcuts
  localparam int          SC_SHIFT    = 10;
  localparam int          SC_BANK1_N  = 5;          // first five shortcuts are bank 1
  localparam int          PMU_ROUTE_W = 4;
  localparam int          NUM_BANKS   = 3;

  // interrupt number = {group, bit}; group 0 is local, 1 basic, 2 bank 1, 3 bank 2
  localparam logic [1:0] GRP_LOCAL = 2'd0;
  localparam logic [1:0] GRP_BASIC = 2'd1;
  localparam logic [1:0] GRP_BANK1 = 2'd2;
  localparam logic [1:0] GRP_BANK2 = 2'd3;

  typedef enum logic [2:0] {
    ACT_DECODE  = 3'd0,
    ACT_EOI     = 3'd1,
    ACT_ENABLE  = 3'd2,
    ACT_DISABLE = 3'd3,
    ACT_QUERY   = 3'd4
  } action_t;

  // index of the lowest set bit, 31 when none is set
  function automatic logic [4:0] low_bit32(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  // shortcut slot to peripheral bit; slots past the table map to bit 30
  function automatic logic [4:0] sc_map(input logic [4:0] idx);
    logic [4:0] r;
    unique case (idx)
      5'd0:    r = 5'd7;
      5'd1:    r = 5'd9;
      5'd2:    r = 5'd10;
      5'd3:    r = 5'd18;
      5'd4:    r = 5'd19;
      5'd5:    r = 5'd21;
      5'd6:    r = 5'd22;
      5'd7:    r = 5'd23;
      5'd8:    r = 5'd24;
      5'd9:    r = 5'd25;
      default: r = 5'd30;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cascaded_irq_decode_and_mask.sv =====
// Cascaded interrupt decode and mask block, top level.
// Depends on cidm_pkg and cascaded_irq_decode_and_mask_macros.svh.
`timescale 1ns / 1ps

// One word in, one word out. Each word names an action in tuser: decode picks the
// highest-priority pending source (local timers, mailboxes, PMU, then the cascade
// through basic bits, shortcut bits, bank 1, bank 2) and masks it; end of
// interrupt and enable set a mask bit, disable clears it, query reads it. The
// word is captured in an input register, worked on by priority encoders and
// mask logic, and the answer lands in an output register; the mask state
// updates on the same edge, so the next word already sees it. out_tvalid
// rises when the held word moves into the output register; one word per cycle
// is sustained while out_tready stays high. Decode results report nothing_pending
// for spurious cases (no local source, or a bare cascade with nothing found).
// Interrupt 8 (cascade) always queries as enabled, 9 (PMU) always as disabled.
// Reset clears every mask.

`include "cascaded_irq_decode_and_mask_macros.svh"

module cascaded_irq_decode_and_mask
  import cidm_pkg::*;
#(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] core, [8:2] irq_number, [18:9] local_source, [39:19] basic_pending,
  // [71:40] bank_one_pending, [103:72] bank_two_pending
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] action
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [6:0] active_irq, [7] nothing_pending, [8] is_enabled, [15:9] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int CORE_IW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  // input register
  logic                 s1_valid_r;
  logic [IN_DATA_W-1:0] s1_data_r;
  logic [IN_USER_W-1:0] s1_user_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  // mask state
  logic [NUM_CORES-1:0][3:0]   timer_en_r,   timer_en_nxt;
  logic [NUM_CORES-1:0][3:0]   mbox_en_r,    mbox_en_nxt;
  logic [PMU_ROUTE_W-1:0]      pmu_route_r,  pmu_route_nxt;
  logic [NUM_BANKS-1:0][31:0]  bank_en_r,    bank_en_nxt;

  logic s1_adv, s1_fire, in_fire;

  // unpacked fields of the held word
  action_t     act;
  logic [1:0]  f_core;
  logic [6:0]  f_irq;
  logic [9:0]  f_local;
  logic [20:0] f_basic;
  logic [31:0] f_bank1;
  logic [31:0] f_bank2;

  logic [CORE_IW+1:0] core_ext;
  logic [CORE_IW-1:0] core_sel;
  logic               core_ok;

  // decode
  logic       dec_found;
  logic [6:0] dec_irq;
  logic [4:0] sc_idx;

  // mask update and query
  logic       upd_en;
  logic       upd_on;
  logic [6:0] op_irq;
  logic [1:0] bank_idx;
  logic       query_bit;

  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign act     = action_t'(s1_user_r);
  assign f_core  = s1_data_r[1:0];
  assign f_irq   = s1_data_r[8:2];
  assign f_local = s1_data_r[18:9];
  assign f_basic = s1_data_r[39:19];
  assign f_bank1 = s1_data_r[71:40];
  assign f_bank2 = s1_data_r[103:72];

  assign core_ext = {{CORE_IW{1'b0}}, f_core};
  assign core_sel = core_ext[CORE_IW-1:0];
  assign core_ok  = core_ext < (CORE_IW+2)'(NUM_CORES);

  // fixed-priority decode of the pending words
  always_comb begin
    dec_found = 1'b0;
    dec_irq   = 7'd0;
    sc_idx    = low_bit32({11'd0, (f_basic & SC_BITS) >> SC_SHIFT});
    priority if ((f_local & TIMER_BITS) != '0) begin
      dec_found = 1'b1;
      dec_irq   = {GRP_LOCAL, low_bit32({22'd0, f_local & TIMER_BITS})};
    end else if ((f_local & MBOX_BITS) != '0) begin
      dec_found = 1'b1;
      dec_irq   = {GRP_LOCAL, low_bit32({22'd0, f_local & MBOX_BITS})};
    end else if (f_local[PMU_BIT]) begin
      dec_found = 1'b1;
      dec_irq   = PMU_IRQ;
    end else if (f_local == '0) begin
      dec_found = 1'b0;
    end else if ((f_basic & BASIC_BITS) != '0) begin
      dec_found = 1'b1;
      dec_irq   = {GRP_BASIC, low_bit32({11'd0, f_basic & BASIC_BITS})};
    end else if ((f_basic & SC_BITS) != '0) begin
      dec_found = 1'b1;
      dec_irq   = {(sc_idx < 5'(SC_BANK1_N)) ? GRP_BANK1 : GRP_BANK2, sc_map(sc_idx)};
    end else if (f_basic[BANK1_FLAG] && f_bank1 != '0) begin
      dec_found = 1'b1;
      dec_irq   = {GRP_BANK1, low_bit32(f_bank1)};
    end else if (f_basic[BANK2_FLAG] && f_bank2 != '0) begin
      dec_found = 1'b1;
      dec_irq   = {GRP_BANK2, low_bit32(f_bank2)};
    end else begin
      dec_found = 1'b0;
    end
  end

  // which mask bit changes, and which way
  always_comb begin
    upd_en = 1'b0;
    upd_on = 1'b0;
    op_irq = f_irq;
    unique case (act)
      ACT_DECODE: begin
        upd_en = dec_found;
        op_irq = dec_irq;
      end
      ACT_EOI, ACT_ENABLE: begin
        upd_en = 1'b1;
        upd_on = 1'b1;
      end
      ACT_DISABLE: upd_en = 1'b1;
      ACT_QUERY:   upd_en = 1'b0;
      default:     upd_en = 1'b0;
    endcase
  end

  assign bank_idx = op_irq[6:5] - 2'd1;

  always_comb begin
    timer_en_nxt  = timer_en_r;
    mbox_en_nxt   = mbox_en_r;
    pmu_route_nxt = pmu_route_r;
    bank_en_nxt   = bank_en_r;
    if (upd_en) begin
      if (op_irq[6:5] == GRP_LOCAL) begin
        // unused local numbers and the cascade number fall through untouched
        priority if (op_irq <= 7'd3) begin
          if (core_ok) timer_en_nxt[core_sel][op_irq[1:0]] = upd_on;
        end else if (op_irq <= 7'd7) begin
          if (core_ok) mbox_en_nxt[core_sel][op_irq[1:0]] = upd_on;
        end else if (op_irq == PMU_IRQ) begin
          if (core_ok) pmu_route_nxt[f_core] = upd_on;
        end else begin
          pmu_route_nxt = pmu_route_r;
        end
      end else begin
        bank_en_nxt[bank_idx][op_irq[4:0]] = upd_on;
      end
    end
  end

  // enable query
  always_comb begin
    query_bit = 1'b0;
    if (f_irq[6:5] == GRP_LOCAL) begin
      priority if (f_irq <= 7'd3) begin
        query_bit = core_ok && timer_en_r[core_sel][f_irq[1:0]];
      end else if (f_irq <= 7'd7) begin
        query_bit = core_ok && mbox_en_r[core_sel][f_irq[1:0]];
      end else begin
        query_bit = (f_irq == CASCADE_IRQ);
      end
    end else begin
      query_bit = bank_en_r[f_irq[6:5] - 2'd1][f_irq[4:0]];
    end
  end

  always_comb begin
    out_data_nxt = '0;
    unique case (act)
      ACT_DECODE: begin
        out_data_nxt[6:0] = dec_found ? dec_irq : 7'd0;
        out_data_nxt[7]   = !dec_found;
      end
      ACT_QUERY: out_data_nxt[8] = query_bit;
      ACT_EOI, ACT_ENABLE, ACT_DISABLE: out_data_nxt = '0;
      default: out_data_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timer_en_r  <= '0;
      mbox_en_r   <= '0;
      pmu_route_r <= '0;
      bank_en_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        timer_en_r  <= timer_en_nxt;
        mbox_en_r   <= mbox_en_nxt;
        pmu_route_r <= pmu_route_nxt;
        bank_en_r   <= bank_en_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  `CIDM_ASSERT_NOW(a_spurious_zero, out_valid_r && out_data_r[7], out_data_r[6:0] == 7'd0, "spurious decode with nonzero irq")
  `CIDM_ASSERT_NOW(a_excl_answer, out_valid_r, !(out_data_r[7] && out_data_r[8]), "decode and query answers both set")
  `CIDM_ASSERT_NOW(a_no_cascade, out_valid_r && !out_data_r[7] && out_data_r[8] == 1'b0 && out_data_r[6:0] != 7'd0, out_data_r[6:0] != CASCADE_IRQ, "cascade number decoded")
  `CIDM_ASSERT_NEXT(a_fire_valid, s1_fire, out_valid_r, "processed word lost before output")
  `CIDM_ASSERT_NEXT(a_disable_bank, s1_fire && act == ACT_DISABLE && f_irq[6:5] != GRP_LOCAL, !bank_en_r[$past(f_irq[6:5]) - 2'd1][$past(f_irq[4:0])], "bank disable did not clear")

endmodule
